>>> rtl/core/adsr_envelope_generator_macros.svh
// assertion macros for the adsr envelope generator
`ifndef ADSR_ENVELOPE_GENERATOR_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

`define ADSR_ASSERT_IMP(lbl, clk_i, rst_n_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error(msg);

`define ADSR_ASSERT_NXT(lbl, clk_i, rst_n_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ADSR_ASSERT_IMP(lbl, clk_i, rst_n_i, ante, cons, msg)

`define ADSR_ASSERT_NXT(lbl, clk_i, rst_n_i, ante, cons, msg)

`endif

`endif

>>> rtl/core/adsr_pkg.sv
// shared types and constants for the adsr envelope generator
package adsr_pkg;

	localparam int LEVEL_BITS_DEF = 24;
	localparam int PHASE_BITS     = 3;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [31:0] ATTACK_STEP_RESET   = 32'd437;
	localparam logic [31:0] DECAY_STEP_RESET    = 32'd105;
	localparam logic [31:0] SUSTAIN_LEVEL_RESET = 32'd14260633;
	localparam logic [31:0] RELEASE_STEP_RESET  = 32'd117;

	localparam logic [CFG_INDEX_BITS-1:0] REG_ATTACK_STEP   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_STEP    = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SUSTAIN_LEVEL = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RELEASE_STEP  = 2'd3;

	typedef enum logic [PHASE_BITS-1:0] {
		ST_IDLE    = 3'd0,
		ST_ATTACK  = 3'd1,
		ST_DECAY   = 3'd2,
		ST_SUSTAIN = 3'd3,
		ST_RELEASE = 3'd4
	} stage_t;

endpackage

>>> rtl/core/adsr_step.sv
// next stage and next level of the envelope for one gate sample
module adsr_step #(
	parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF
) (
	input  logic                  gate,
	input  adsr_pkg::stage_t      stage,
	input  logic [LEVEL_BITS-1:0] level_cur,
	input  logic [LEVEL_BITS-1:0] attack_step,
	input  logic [LEVEL_BITS-1:0] decay_step,
	input  logic [LEVEL_BITS-1:0] sustain_level,
	input  logic [LEVEL_BITS-1:0] release_step,
	output adsr_pkg::stage_t      stage_nxt,
	output logic [LEVEL_BITS-1:0] level_nxt
);

	localparam logic [LEVEL_BITS-1:0] FULL_SCALE = {LEVEL_BITS{1'b1}};

	adsr_pkg::stage_t    stage_g;
	logic [LEVEL_BITS:0] attack_sum;
	logic [LEVEL_BITS-1:0] decay_diff;
	logic [LEVEL_BITS-1:0] release_diff;

	assign attack_sum   = {1'b0, level_cur} + {1'b0, attack_step};
	assign decay_diff   = level_cur - decay_step;
	assign release_diff = level_cur - release_step;

	// gate first
	always_comb begin
		unique case (stage) inside
			adsr_pkg::ST_IDLE, adsr_pkg::ST_RELEASE: begin
				stage_g = gate ? adsr_pkg::ST_ATTACK : stage;
			end
			adsr_pkg::ST_ATTACK, adsr_pkg::ST_DECAY, adsr_pkg::ST_SUSTAIN: begin
				stage_g = gate ? stage : adsr_pkg::ST_RELEASE;
			end
			default: begin
				stage_g = gate ? adsr_pkg::ST_ATTACK : adsr_pkg::ST_IDLE;
			end
		endcase
	end

	// then one linear step
	always_comb begin
		stage_nxt = stage_g;
		level_nxt = '0;
		unique case (stage_g)
			adsr_pkg::ST_ATTACK: begin
				if (attack_sum >= {1'b0, FULL_SCALE}) begin
					level_nxt = FULL_SCALE;
					stage_nxt = adsr_pkg::ST_DECAY;
				end else begin
					level_nxt = attack_sum[LEVEL_BITS-1:0];
				end
			end
			adsr_pkg::ST_DECAY: begin
				if (level_cur <= decay_step || decay_diff <= sustain_level) begin
					level_nxt = sustain_level;
					stage_nxt = adsr_pkg::ST_SUSTAIN;
				end else begin
					level_nxt = decay_diff;
				end
			end
			adsr_pkg::ST_SUSTAIN: begin
				level_nxt = sustain_level;
			end
			adsr_pkg::ST_RELEASE: begin
				if (level_cur <= release_step) begin
					level_nxt = '0;
					stage_nxt = adsr_pkg::ST_IDLE;
				end else begin
					level_nxt = release_diff;
				end
			end
			default: begin
				level_nxt = '0;
				stage_nxt = adsr_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/core/adsr_envelope_generator.sv
// Linear ADSR envelope generator. Each accepted word carries one gate sample and yields
// exactly one result word with the level and phase after that tick. One word is taken
// every clock cycle while the output is not blocked; out_valid rises once its word
// has passed the input register and then the result register, and the rate is set by
// the single add or subtract with clamp between the input register and the stage and
// level registers. A stalled result holds the input register, so new words wait only
// while the output is blocked. The configuration port writes the step and sustain
// registers and should only be used while no word is in flight.
`include "adsr_envelope_generator_macros.svh"

module adsr_envelope_generator #(
	parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                gate_on,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [LEVEL_BITS-1:0]               level,
	output logic [adsr_pkg::PHASE_BITS-1:0]     phase,
	input  logic                                cfg_we,
	input  logic [adsr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [LEVEL_BITS-1:0]               cfg_data
);

	localparam logic [LEVEL_BITS-1:0] FULL_SCALE = {LEVEL_BITS{1'b1}};
	localparam logic [LEVEL_BITS-1:0] ATTACK_RST =
		LEVEL_BITS'(adsr_pkg::ATTACK_STEP_RESET);
	localparam logic [LEVEL_BITS-1:0] DECAY_RST =
		LEVEL_BITS'(adsr_pkg::DECAY_STEP_RESET);
	localparam logic [LEVEL_BITS-1:0] SUSTAIN_RST =
		LEVEL_BITS'(adsr_pkg::SUSTAIN_LEVEL_RESET);
	localparam logic [LEVEL_BITS-1:0] RELEASE_RST =
		LEVEL_BITS'(adsr_pkg::RELEASE_STEP_RESET);

	logic [LEVEL_BITS-1:0] attack_q;
	logic [LEVEL_BITS-1:0] decay_q;
	logic [LEVEL_BITS-1:0] sustain_q;
	logic [LEVEL_BITS-1:0] release_q;

	logic                  in_valid_s1;
	logic                  gate_s1;
	logic                  adv_s1;

	logic                  out_valid_s2;
	logic [LEVEL_BITS-1:0] level_s2;
	adsr_pkg::stage_t      phase_s2;

	adsr_pkg::stage_t      stage_q;
	logic [LEVEL_BITS-1:0] level_q;
	adsr_pkg::stage_t      stage_nxt;
	logic [LEVEL_BITS-1:0] level_nxt;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= ATTACK_RST;
			decay_q   <= DECAY_RST;
			sustain_q <= SUSTAIN_RST;
			release_q <= RELEASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				adsr_pkg::REG_ATTACK_STEP:   attack_q  <= cfg_data;
				adsr_pkg::REG_DECAY_STEP:    decay_q   <= cfg_data;
				adsr_pkg::REG_SUSTAIN_LEVEL: sustain_q <= cfg_data;
				adsr_pkg::REG_RELEASE_STEP:  release_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign adv_s1   = in_valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !in_valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			gate_s1 <= gate_on;
		end
	end

	adsr_step #(
		.LEVEL_BITS (LEVEL_BITS)
	) u_step (
		.gate          (gate_s1),
		.stage         (stage_q),
		.level_cur     (level_q),
		.attack_step   (attack_q),
		.decay_step    (decay_q),
		.sustain_level (sustain_q),
		.release_step  (release_q),
		.stage_nxt     (stage_nxt),
		.level_nxt     (level_nxt)
	);

	// envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= adsr_pkg::ST_IDLE;
			level_q <= '0;
		end else if (adv_s1) begin
			stage_q <= stage_nxt;
			level_q <= level_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			level_s2 <= level_nxt;
			phase_s2 <= stage_nxt;
		end
	end

	assign out_valid = out_valid_s2;
	assign level     = level_s2;
	assign phase     = phase_s2;

	`ADSR_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !out_valid_s2, in_ready, "input stalled with result register empty")
	`ADSR_ASSERT_IMP(a_result_is_state, clk, arst_n, out_valid_s2, level_s2 == level_q, "waiting result differs from envelope level")
	`ADSR_ASSERT_IMP(a_idle_is_zero, clk, arst_n, out_valid_s2 && phase_s2 == adsr_pkg::ST_IDLE, level_s2 == '0, "idle result with non-zero level")
	`ADSR_ASSERT_IMP(a_sustain_level, clk, arst_n, out_valid_s2 && phase_s2 == adsr_pkg::ST_SUSTAIN, level_s2 == sustain_q, "sustain result off the sustain level")
	`ADSR_ASSERT_NXT(a_attack_peak, clk, arst_n, adv_s1 && stage_nxt == adsr_pkg::ST_DECAY && level_q != FULL_SCALE && stage_q != adsr_pkg::ST_DECAY, level_q == FULL_SCALE, "attack left without reaching full scale")

endmodule

>>> tb/tb.sv
// testbench for the adsr envelope generator: table and random gate words against a model
`timescale 1ns / 1ps

module tb;

	localparam int LW = adsr_pkg::LEVEL_BITS_DEF;
	localparam int IW = adsr_pkg::CFG_INDEX_BITS;
	localparam logic [LW-1:0] FULL_SCALE = {LW{1'b1}};
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 8;
	localparam int WORDS_PER_PHASE = 170;

	typedef struct {
		logic [LW-1:0]    lvl;
		adsr_pkg::stage_t stg;
	} env_out_t;

	typedef enum logic [1:0] {ROW_WR, ROW_TICK, ROW_KNOWN} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [IW-1:0]    idx;
		logic [LW-1:0]    data;
		bit               gate;
		logic [LW-1:0]    lvl;
		adsr_pkg::stage_t stg;
	} dir_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic                            gate_on;
	logic                            out_valid;
	logic                            out_ready = 1'b0;
	logic [LW-1:0]                   level;
	logic [adsr_pkg::PHASE_BITS-1:0] phase;
	logic                            cfg_we;
	logic [IW-1:0]                   cfg_index;
	logic [LW-1:0]                   cfg_data;

	logic [LW-1:0]    attack_step;
	logic [LW-1:0]    decay_step;
	logic [LW-1:0]    sustain_level;
	logic [LW-1:0]    release_step;
	logic [LW-1:0]    env_level;
	adsr_pkg::stage_t env_stage;

	env_out_t expected_q[$];
	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	int words_sent;
	int results_checked;
	int reg_writes;
	int cycles;
	int stage_hits [5];

	dir_row_t dir_tab [42] = '{
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_WR, adsr_pkg::REG_ATTACK_STEP, FULL_SCALE, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_WR, adsr_pkg::REG_DECAY_STEP, FULL_SCALE, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_WR, adsr_pkg::REG_SUSTAIN_LEVEL, 24'h800000, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_WR, adsr_pkg::REG_RELEASE_STEP, FULL_SCALE, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b1, FULL_SCALE, adsr_pkg::ST_DECAY},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b1, 24'h800000, adsr_pkg::ST_SUSTAIN},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b1, 24'h800000, adsr_pkg::ST_SUSTAIN},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_WR, adsr_pkg::REG_ATTACK_STEP, 24'd1, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_WR, adsr_pkg::REG_DECAY_STEP, 24'd0, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_WR, adsr_pkg::REG_SUSTAIN_LEVEL, FULL_SCALE, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_WR, adsr_pkg::REG_RELEASE_STEP, 24'd0, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b1, 24'd1, adsr_pkg::ST_ATTACK},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b1, 24'd2, adsr_pkg::ST_ATTACK},
		'{ROW_WR, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b1, 24'd2, adsr_pkg::ST_ATTACK},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b0, 24'd2, adsr_pkg::ST_RELEASE},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b0, 24'd2, adsr_pkg::ST_RELEASE},
		'{ROW_WR, adsr_pkg::REG_RELEASE_STEP, FULL_SCALE, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_WR, adsr_pkg::REG_ATTACK_STEP, FULL_SCALE, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b1, FULL_SCALE, adsr_pkg::ST_DECAY},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b1, FULL_SCALE, adsr_pkg::ST_SUSTAIN},
		'{ROW_WR, adsr_pkg::REG_SUSTAIN_LEVEL, 24'd0, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b1, 24'd0, adsr_pkg::ST_SUSTAIN},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_WR, adsr_pkg::REG_ATTACK_STEP, 24'h100000, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_WR, adsr_pkg::REG_DECAY_STEP, 24'h000010, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_WR, adsr_pkg::REG_SUSTAIN_LEVEL, 24'h400000, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_WR, adsr_pkg::REG_RELEASE_STEP, 24'h001000, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b1, 24'h100000, adsr_pkg::ST_ATTACK},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b0, 24'h0ff000, adsr_pkg::ST_RELEASE},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b1, 24'h1ff000, adsr_pkg::ST_ATTACK},
		'{ROW_WR, adsr_pkg::REG_ATTACK_STEP, FULL_SCALE, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b1, FULL_SCALE, adsr_pkg::ST_DECAY},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b1, 24'hffffef, adsr_pkg::ST_DECAY},
		'{ROW_WR, adsr_pkg::REG_SUSTAIN_LEVEL, FULL_SCALE, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_KNOWN, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b1, FULL_SCALE, adsr_pkg::ST_SUSTAIN},
		'{ROW_TICK, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b0, 24'd0, adsr_pkg::ST_IDLE},
		'{ROW_TICK, adsr_pkg::REG_ATTACK_STEP, 24'd0, 1'b1, 24'd0, adsr_pkg::ST_IDLE}
	};

	adsr_envelope_generator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.gate_on(gate_on),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.level(level),
		.phase(phase),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic env_out_t advance_envelope(input bit g);
		env_out_t r;
		logic [LW:0] sum;
		if (g) begin
			if (env_stage == adsr_pkg::ST_IDLE || env_stage == adsr_pkg::ST_RELEASE)
				env_stage = adsr_pkg::ST_ATTACK;
		end else if (env_stage != adsr_pkg::ST_IDLE && env_stage != adsr_pkg::ST_RELEASE) begin
			env_stage = adsr_pkg::ST_RELEASE;
		end
		case (env_stage)
			adsr_pkg::ST_ATTACK: begin
				sum = {1'b0, env_level} + {1'b0, attack_step};
				if (sum >= {1'b0, FULL_SCALE}) begin
					env_level = FULL_SCALE;
					env_stage = adsr_pkg::ST_DECAY;
				end else begin
					env_level = sum[LW-1:0];
				end
			end
			adsr_pkg::ST_DECAY: begin
				if (env_level <= decay_step || env_level - decay_step <= sustain_level) begin
					env_level = sustain_level;
					env_stage = adsr_pkg::ST_SUSTAIN;
				end else begin
					env_level = env_level - decay_step;
				end
			end
			adsr_pkg::ST_SUSTAIN: env_level = sustain_level;
			adsr_pkg::ST_RELEASE: begin
				if (env_level <= release_step) begin
					env_level = '0;
					env_stage = adsr_pkg::ST_IDLE;
				end else begin
					env_level = env_level - release_step;
				end
			end
			default: begin
				env_level = '0;
				env_stage = adsr_pkg::ST_IDLE;
			end
		endcase
		r.lvl = env_level;
		r.stg = env_stage;
		return r;
	endfunction

	function automatic logic [LW-1:0] pick_step(input int max_shift);
		if ($urandom_range(9) == 0)
			return LW'($urandom_range(1, FULL_SCALE));
		return (FULL_SCALE >> $urandom_range(1, max_shift)) ^ LW'($urandom_range(0, 255));
	endfunction

	function automatic void report_mismatch(input string what, input logic [LW-1:0] want,
			input logic [LW-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch at result %0d: expected %0h, got %0h",
				$time, what, results_checked, want, got);
	endfunction

	task automatic send_gate(input bit g, input bit known, input logic [LW-1:0] lvl,
			input adsr_pkg::stage_t stg);
		env_out_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		r = advance_envelope(g);
		if (known) begin
			r.lvl = lvl;
			r.stg = stg;
		end
		expected_q.push_back(r);
		stage_hits[r.stg]++;
		words_sent++;
		in_valid <= 1'b1;
		gate_on <= g;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [IW-1:0] idx, input logic [LW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			adsr_pkg::REG_ATTACK_STEP:   attack_step = val;
			adsr_pkg::REG_DECAY_STEP:    decay_step = val;
			adsr_pkg::REG_SUSTAIN_LEVEL: sustain_level = val;
			adsr_pkg::REG_RELEASE_STEP:  release_step = val;
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_envelope(input logic [LW-1:0] a, input logic [LW-1:0] d,
			input logic [LW-1:0] s, input logic [LW-1:0] r);
		drain_pipe();
		write_reg(adsr_pkg::REG_ATTACK_STEP, a);
		write_reg(adsr_pkg::REG_DECAY_STEP, d);
		write_reg(adsr_pkg::REG_SUSTAIN_LEVEL, s);
		write_reg(adsr_pkg::REG_RELEASE_STEP, r);
		cfg_we <= 1'b0;
	endtask

	// result checking
	always @(posedge clk) begin
		env_out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected word", '0, level);
			end else begin
				e = expected_q.pop_front();
				results_checked++;
				if (level !== e.lvl)
					report_mismatch("level", e.lvl, level);
				if (phase !== e.stg)
					report_mismatch("phase", LW'(e.stg), LW'(phase));
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d results outstanding",
				cycles, expected_q.size());
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		bit writing;
		int n;
		int run;
		int hold;
		int k;
		arst_n = 1'b0;
		in_valid = 1'b0;
		gate_on = 1'b0;
		cfg_we = 1'b0;
		cfg_index = adsr_pkg::REG_ATTACK_STEP;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		attack_step = adsr_pkg::ATTACK_STEP_RESET[LW-1:0];
		decay_step = adsr_pkg::DECAY_STEP_RESET[LW-1:0];
		sustain_level = adsr_pkg::SUSTAIN_LEVEL_RESET[LW-1:0];
		release_step = adsr_pkg::RELEASE_STEP_RESET[LW-1:0];
		env_level = '0;
		env_stage = adsr_pkg::ST_IDLE;
		writing = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_WR) begin
				if (!writing)
					drain_pipe();
				write_reg(dir_tab[i].idx, dir_tab[i].data);
				writing = 1'b1;
			end else begin
				if (writing)
					cfg_we <= 1'b0;
				writing = 1'b0;
				send_gate(dir_tab[i].gate, dir_tab[i].kind == ROW_KNOWN,
					dir_tab[i].lvl, dir_tab[i].stg);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: set_envelope(FULL_SCALE, FULL_SCALE, FULL_SCALE, FULL_SCALE);
				1: set_envelope(LW'(1), LW'(1), '0, LW'(1));
				default: set_envelope(pick_step(5), pick_step(6),
					LW'($urandom_range(0, FULL_SCALE)), pick_step(6));
			endcase
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 58;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 58;
				end
				default: begin
					send_idle_pct = 27;
					recv_stall_pct = 27;
				end
			endcase
			n = 0;
			while (n < WORDS_PER_PHASE) begin
				if ($urandom_range(4) == 0) begin
					// short burst of random gate chatter
					run = $urandom_range(1, 8);
					if (run > WORDS_PER_PHASE - n)
						run = WORDS_PER_PHASE - n;
					for (k = 0; k < run; k++)
						send_gate(1'($urandom_range(1)), 1'b0, '0, adsr_pkg::ST_IDLE);
					n += run;
				end else begin
					run = $urandom_range(1, 70);
					hold = $urandom_range(1, 50);
					if (run > WORDS_PER_PHASE - n)
						run = WORDS_PER_PHASE - n;
					if (hold > WORDS_PER_PHASE - n - run)
						hold = WORDS_PER_PHASE - n - run;
					for (k = 0; k < run; k++)
						send_gate(1'b1, 1'b0, '0, adsr_pkg::ST_IDLE);
					for (k = 0; k < hold; k++)
						send_gate(1'b0, 1'b0, '0, adsr_pkg::ST_IDLE);
					n += run + hold;
				end
			end
		end

		drain_pipe();
		repeat (6) @(negedge clk);
		$display("%0d gate words, %0d results checked, %0d register writes over %0d phases",
			words_sent, results_checked, reg_writes, PHASES);
		$display("results by stage: idle %0d, attack %0d, decay %0d, sustain %0d, release %0d",
			stage_hits[adsr_pkg::ST_IDLE], stage_hits[adsr_pkg::ST_ATTACK],
			stage_hits[adsr_pkg::ST_DECAY], stage_hits[adsr_pkg::ST_SUSTAIN],
			stage_hits[adsr_pkg::ST_RELEASE]);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
